// File: rtl/core/ppg_pkg.sv
// Shared types, constants and constant tables of the plasma pixel generator.
package ppg_pkg;

  // Block parameters.
  localparam int MAX_WIDTH        = 64;
  localparam int MAX_HEIGHT       = 16;
  localparam int PERIOD_MS        = 62832;
  localparam int SINE_TABLE_DEPTH = 256;

  // Field and register widths.
  localparam int X_W       = 6;
  localparam int Y_W       = 4;
  localparam int ELAPSED_W = 10;
  localparam int SPEED_W   = 10;
  localparam int TINT_W    = 24;
  localparam int PW_W      = 7;
  localparam int PH_W      = 5;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int TURN_W    = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TINT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(4);

  // Register reset values.
  localparam logic [SPEED_W-1:0] SPEED_RESET  = SPEED_W'(50);
  localparam logic [TINT_W-1:0]  TINT_RESET   = TINT_W'(24'h40C0FF);
  localparam logic [PW_W-1:0]    WIDTH_RESET  = PW_W'(40);
  localparam logic [PH_W-1:0]    HEIGHT_RESET = PH_W'(12);

  // Time advance: floor(n/50) as (n*DIV50_MUL) >> DIV50_SHIFT for n below 2^20.
  localparam int PROD_W      = ELAPSED_W + SPEED_W;
  localparam int DIV50_MUL   = 1342178;
  localparam int DIV50_SHIFT = 26;
  localparam int ADV_W       = 15;

  // Time mod 1000: quotient as (t*MOD1000_MUL) >> MOD1000_SHIFT.
  localparam int MOD1000_MUL   = 67109;
  localparam int MOD1000_SHIFT = 26;
  localparam int Q1000_W       = 7;
  localparam int WINDOW_MS     = 40;

  // Time to turns at the three wave rates.
  localparam int RATE_10 = 683565;
  localparam int RATE_07 = 478496;
  localparam int RATE_13 = 888635;

  // Coordinate reciprocal table: entry d-1 holds ceil(2^RECIP_SHIFT / d).
  localparam int RECIP_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int RIDX_W      = (RECIP_DEPTH > 1) ? $clog2(RECIP_DEPTH) : 1;
  localparam int RECIP_SHIFT = TURN_W + X_W + RIDX_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  typedef logic [RECIP_W-1:0] recip_arr_t [0:RECIP_DEPTH-1];

  function automatic recip_arr_t build_recip();
    recip_arr_t  tab;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    for (int d = 1; d <= RECIP_DEPTH; d++) begin
      num = (64'd1 << RECIP_SHIFT) - 64'd1;
      rem = '0;
      quo = '0;
      // Restoring long division of 2^k - 1 by d.
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= 64'(d)) begin
          rem    = rem - 64'(d);
          quo[b] = 1'b1;
        end
      end
      tab[d-1] = RECIP_W'(quo + 64'd1);
    end
    return tab;
  endfunction

  localparam recip_arr_t RECIP_TAB = build_recip();

  // Quarter-wave sine table, Q1.14 magnitudes.
  localparam int HALF_PI_Q30 = 1686629713;
  localparam int SIN_IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SIN_MAG_W   = 15;
  localparam int SIN_W       = 16;

  typedef logic [SIN_MAG_W-1:0] sine_arr_t [0:SINE_TABLE_DEPTH];

  function automatic sine_arr_t build_sine();
    sine_arr_t          tab;
    logic        [63:0] a;
    logic        [63:0] a2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] mag;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      a    = (64'(i) * 64'(HALF_PI_Q30)) / 64'(SINE_TABLE_DEPTH);
      a2   = (a * a) >> 30;
      term = a;
      sum  = $signed(a);
      // Taylor series in Q30, odd terms up to the eleventh power.
      for (int k = 1; k <= 5; k++) begin
        term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      mag    = (64'(sum) + 64'd32768) >> 16;
      tab[i] = SIN_MAG_W'(mag);
    end
    return tab;
  endfunction

  localparam sine_arr_t SINE_TAB = build_sine();

  // Square root of fx^2 + fy^2: one result bit per iteration.
  localparam int SQ_W         = 2 * TURN_W + 1;
  localparam int SQRT_W       = SQ_W + 2;
  localparam int SQRT_ITERS   = 17;
  localparam int SQRT_STAGES  = (SQRT_ITERS + 1) / 2;
  localparam int SQRT_TOP_SH  = 2 * (SQRT_ITERS - 1);

  // Level mapping.
  localparam int LEVEL_BIAS  = 49152;
  localparam int LEVEL_FULL  = 98304;
  localparam int LEVEL_W     = 17;
  localparam int DIV3_MUL    = 683;
  localparam int DIV255_MUL  = 65794;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [TINT_W-1:0]  tint;
    logic               invert;
    logic [PW_W-1:0]    width;
    logic [PH_W-1:0]    height;
  } cfg_t;

  // Pixel payload carried past the front end.
  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic              oor;
    logic              sw;
    logic [TURN_W-1:0] p1;
    logic [TURN_W-1:0] p2;
    logic [TURN_W-1:0] t13;
  } pay_t;

  typedef struct packed {
    logic            valid;
    pay_t            pay;
    logic [SQ_W-1:0] rsq;
  } front_t;

  typedef struct packed {
    logic              valid;
    pay_t              pay;
    logic [TURN_W-1:0] rad;
  } root_t;

  typedef struct packed {
    logic              valid;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              sw;
    logic              oor;
  } result_t;

endpackage

// File: rtl/core/ppg_front.sv
// Front end: time accumulator, coordinate phases, wave times and radius square.
module ppg_front
  import ppg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  logic                 frame_start,
  input  logic [ELAPSED_W-1:0] elapsed_ms,
  input  logic [X_W-1:0]       pixel_x,
  input  logic [Y_W-1:0]       pixel_y,
  output front_t               front
);

  // Stage 1 registers.
  logic                  v1;
  logic                  fs1;
  logic [X_W-1:0]        x1;
  logic [Y_W-1:0]        y1;
  logic                  oor1;
  logic [PROD_W-1:0]     prod1;
  logic [RECIP_W-1:0]    mw1;
  logic [RECIP_W-1:0]    mh1;

  // Stage 2 registers.
  logic                  v2;
  logic                  fs2;
  logic [X_W-1:0]        x2;
  logic [Y_W-1:0]        y2;
  logic                  oor2;
  logic [ADV_W-1:0]      adv2;
  logic [TURN_W-1:0]     fx2;
  logic [TURN_W-1:0]     fy2;

  // Stage 3 registers and the accumulator.
  logic [TURN_W-1:0]     phase;
  logic [TURN_W-1:0]     phase_next;
  logic                  v3;
  logic [X_W-1:0]        x3;
  logic [Y_W-1:0]        y3;
  logic                  oor3;
  logic [TURN_W-1:0]     ph3;
  logic [TURN_W-1:0]     fx3;
  logic [TURN_W-1:0]     fy3;
  logic [2*TURN_W-1:0]   sqx3;
  logic [2*TURN_W-1:0]   sqy3;

  // Stage 4 registers.
  logic                  v4;
  logic [X_W-1:0]        x4;
  logic [Y_W-1:0]        y4;
  logic                  oor4;
  logic [TURN_W-1:0]     ph4;
  logic [TURN_W-1:0]     fx4;
  logic [TURN_W-1:0]     fy4;
  logic [TURN_W-1:0]     t1_4;
  logic [TURN_W-1:0]     t07_4;
  logic [TURN_W-1:0]     t13_4;
  logic [Q1000_W-1:0]    q4;
  logic [SQ_W-1:0]       rsq4;

  // Effective panel size and reciprocal lookups.
  logic [PW_W-1:0]       w_eff;
  logic [PH_W-1:0]       h_eff;
  logic [RIDX_W-1:0]     w_idx;
  logic [RIDX_W-1:0]     h_idx;
  logic                  oor_in;

  always_comb begin
    w_eff  = (int'(cfg.width) > MAX_WIDTH) ? PW_W'(MAX_WIDTH) : cfg.width;
    h_eff  = (int'(cfg.height) > MAX_HEIGHT) ? PH_W'(MAX_HEIGHT) : cfg.height;
    w_idx  = (w_eff == '0) ? '0 : RIDX_W'(32'(w_eff) - 32'd1);
    h_idx  = (h_eff == '0) ? '0 : RIDX_W'(32'(h_eff) - 32'd1);
    oor_in = (PW_W'(pixel_x) >= w_eff) || (PH_W'(pixel_y) >= h_eff);
  end

  // Stage 1: raw advance product and reciprocals.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs1   <= frame_start;
      x1    <= pixel_x;
      y1    <= pixel_y;
      oor1  <= oor_in;
      prod1 <= PROD_W'(elapsed_ms) * PROD_W'(cfg.speed);
      mw1   <= RECIP_TAB[w_idx];
      mh1   <= RECIP_TAB[h_idx];
    end
  end

  // Stage 2: advance divided by 50, coordinate phases by reciprocal.
  logic [PROD_W+22:0]    adv_full;
  logic [RECIP_W+X_W-1:0] fx_full;
  logic [RECIP_W+X_W-1:0] fy_full;

  always_comb begin
    adv_full = (PROD_W+23)'(prod1) * (PROD_W+23)'(DIV50_MUL);
    fx_full  = (RECIP_W+X_W)'(x1) * (RECIP_W+X_W)'(mw1);
    fy_full  = (RECIP_W+X_W)'(y1) * (RECIP_W+X_W)'(mh1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs2  <= fs1;
      x2   <= x1;
      y2   <= y1;
      oor2 <= oor1;
      adv2 <= adv_full[DIV50_SHIFT +: ADV_W];
      fx2  <= fx_full[RECIP_SHIFT-TURN_W +: TURN_W];
      fy2  <= fy_full[RECIP_SHIFT-TURN_W +: TURN_W];
    end
  end

  // Stage 3: time accumulator, advanced once per frame start, wrapped once.
  logic [TURN_W:0] tsum;

  always_comb begin
    tsum       = {1'b0, phase} + (TURN_W+1)'(adv2);
    phase_next = phase;
    if (fs2) begin
      if (tsum >= (TURN_W+1)'(PERIOD_MS)) begin
        phase_next = TURN_W'(tsum - (TURN_W+1)'(PERIOD_MS));
      end else begin
        phase_next = tsum[TURN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      v3    <= 1'b0;
    end else if (en) begin
      v3 <= v2;
      if (v2) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3   <= x2;
      y3   <= y2;
      oor3 <= oor2;
      ph3  <= phase_next;
      fx3  <= fx2;
      fy3  <= fy2;
      sqx3 <= (2*TURN_W)'(fx2) * (2*TURN_W)'(fx2);
      sqy3 <= (2*TURN_W)'(fy2) * (2*TURN_W)'(fy2);
    end
  end

  // Stage 4: time in turns at each rate, mod-1000 quotient, radius square.
  logic [TURN_W+20:0] t1_full;
  logic [TURN_W+20:0] t07_full;
  logic [TURN_W+20:0] t13_full;
  logic [TURN_W+17:0] q_full;

  always_comb begin
    t1_full  = (TURN_W+21)'(ph3) * (TURN_W+21)'(RATE_10);
    t07_full = (TURN_W+21)'(ph3) * (TURN_W+21)'(RATE_07);
    t13_full = (TURN_W+21)'(ph3) * (TURN_W+21)'(RATE_13);
    q_full   = (TURN_W+18)'(ph3) * (TURN_W+18)'(MOD1000_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4    <= x3;
      y4    <= y3;
      oor4  <= oor3;
      ph4   <= ph3;
      fx4   <= fx3;
      fy4   <= fy3;
      t1_4  <= t1_full[TURN_W +: TURN_W];
      t07_4 <= t07_full[TURN_W +: TURN_W];
      t13_4 <= t13_full[TURN_W +: TURN_W];
      q4    <= q_full[MOD1000_SHIFT +: Q1000_W];
      rsq4  <= SQ_W'(sqx3) + SQ_W'(sqy3);
    end
  end

  // Stage 5: wave phases and the switch window.
  logic [TURN_W:0]   diag;
  logic [TURN_W-1:0] rem1000;

  always_comb begin
    diag    = (TURN_W+1)'(fx4) + (TURN_W+1)'(fy4);
    rem1000 = ph4 - TURN_W'(TURN_W'(q4) * TURN_W'(1000));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (en) begin
      front.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front.pay.x   <= x4;
      front.pay.y   <= y4;
      front.pay.oor <= oor4;
      front.pay.sw  <= (rem1000 < TURN_W'(WINDOW_MS));
      front.pay.p1  <= fx4 + t1_4;
      front.pay.p2  <= diag[TURN_W:1] - t07_4;
      front.pay.t13 <= t13_4;
      front.rsq     <= rsq4;
    end
  end

endmodule

// File: rtl/core/ppg_sqrt.sv
// Pipelined integer square root, two result bits per stage.
module ppg_sqrt
  import ppg_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  front_t front,
  output root_t  root
);

  typedef struct packed {
    logic [SQRT_W-1:0] n;
    logic [SQRT_W-1:0] r;
  } sq_state_t;

  // One digit-by-digit step with the trial bit at position sh.
  function automatic sq_state_t sq_step(sq_state_t s, int sh);
    sq_state_t         o;
    logic [SQRT_W-1:0] bitv;
    logic [SQRT_W-1:0] trial;
    bitv  = SQRT_W'(1) << sh;
    trial = s.r + bitv;
    if (s.n >= trial) begin
      o.n = s.n - trial;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  logic      stv [SQRT_STAGES];
  pay_t      stp [SQRT_STAGES];
  sq_state_t sts [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam int SH0 = SQRT_TOP_SH - 4 * s;
    localparam int SH1 = SQRT_TOP_SH - 4 * s - 2;

    logic      vin;
    pay_t      pin;
    sq_state_t sin;
    sq_state_t smid;
    sq_state_t sout;

    if (s == 0) begin : g_first
      always_comb begin
        vin   = front.valid;
        pin   = front.pay;
        sin.n = SQRT_W'(front.rsq);
        sin.r = '0;
      end
    end else begin : g_next
      always_comb begin
        vin = stv[s-1];
        pin = stp[s-1];
        sin = sts[s-1];
      end
    end

    // The last stage does a single step when the iteration count is odd.
    always_comb begin
      smid = sq_step(sin, SH0);
      if (2 * s + 1 < SQRT_ITERS) begin
        sout = sq_step(smid, SH1);
      end else begin
        sout = smid;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stv[s] <= 1'b0;
      end else if (en) begin
        stv[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stp[s] <= pin;
        sts[s] <= sout;
      end
    end
  end

  assign root.valid = stv[SQRT_STAGES-1];
  assign root.pay   = stp[SQRT_STAGES-1];
  assign root.rad   = sts[SQRT_STAGES-1].r[TURN_W-1:0];

endmodule

// File: rtl/core/ppg_color.sv
// Back end: three sines, level mapping and tint scaling into the output register.
module ppg_color
  import ppg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cfg_t    cfg,
  input  root_t   root,
  output result_t res
);

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           oor;
    logic           sw;
  } pix_t;

  typedef struct packed {
    logic [SIN_IDX_W-1:0] idx;
    logic                 neg;
  } sidx_t;

  // Quadrant and table index of a phase.
  function automatic sidx_t sine_index(logic [TURN_W-1:0] p);
    sidx_t                 o;
    logic [SIN_IDX_W+13:0] prod;
    logic [SIN_IDX_W-1:0]  idx;
    prod = (SIN_IDX_W+14)'(p[13:0]) * (SIN_IDX_W+14)'(SINE_TABLE_DEPTH);
    idx  = prod[14 +: SIN_IDX_W];
    if (p[14]) begin
      idx = SIN_IDX_W'(SINE_TABLE_DEPTH) - idx;
    end
    o.idx = idx;
    o.neg = p[15];
    return o;
  endfunction

  function automatic logic signed [SIN_W-1:0] sine_val(sidx_t s);
    logic signed [SIN_W-1:0] mag;
    mag = $signed(SIN_W'(SINE_TAB[s.idx]));
    return s.neg ? -mag : mag;
  endfunction

  // Stage 1: table indexes.
  logic  v1;
  pix_t  px1;
  sidx_t i1a;
  sidx_t i1b;
  sidx_t i1c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= root.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= '{x: root.pay.x, y: root.pay.y, oor: root.pay.oor, sw: root.pay.sw};
      i1a <= sine_index(root.pay.p1);
      i1b <= sine_index(root.pay.p2);
      i1c <= sine_index(root.rad - root.pay.t13);
    end
  end

  // Stage 2: signed sine values.
  logic                    v2;
  pix_t                    px2;
  logic signed [SIN_W-1:0] s2a;
  logic signed [SIN_W-1:0] s2b;
  logic signed [SIN_W-1:0] s2c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2 <= px1;
      s2a <= sine_val(i1a);
      s2b <= sine_val(i1b);
      s2c <= sine_val(i1c);
    end
  end

  // Stage 3: biased sum, clamp, optional inversion, times 255 over 2^15.
  logic signed [LEVEL_W:0] tot;
  logic [LEVEL_W-1:0]      lvl;
  logic [LEVEL_W+7:0]      lvl255;
  logic                    v3;
  pix_t                    px3;
  logic [9:0]              u3;

  always_comb begin
    tot = (LEVEL_W+1)'(s2a) + (LEVEL_W+1)'(s2b) + (LEVEL_W+1)'(s2c)
        + (LEVEL_W+1)'(LEVEL_BIAS);
    if (tot < 0) begin
      lvl = '0;
    end else if (tot > (LEVEL_W+1)'(LEVEL_FULL)) begin
      lvl = LEVEL_W'(LEVEL_FULL);
    end else begin
      lvl = LEVEL_W'(tot);
    end
    if (cfg.invert) begin
      lvl = LEVEL_W'(LEVEL_FULL) - lvl;
    end
    lvl255 = (LEVEL_W+8)'(lvl) * (LEVEL_W+8)'(255);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px3 <= px2;
      u3  <= lvl255[15 +: 10];
    end
  end

  // Stage 4: divide by three for the level 0..255.
  logic [19:0]       u_mul;
  logic              v4;
  pix_t              px4;
  logic [CHAN_W-1:0] lv4;

  assign u_mul = 20'(u3) * 20'(DIV3_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px4 <= px3;
      lv4 <= u_mul[11 +: CHAN_W];
    end
  end

  // Stage 5: tint channel times level.
  logic                v5;
  pix_t                px5;
  logic [2*CHAN_W-1:0] pr5;
  logic [2*CHAN_W-1:0] pg5;
  logic [2*CHAN_W-1:0] pb5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px5 <= px4;
      pr5 <= (2*CHAN_W)'(cfg.tint[23:16]) * (2*CHAN_W)'(lv4);
      pg5 <= (2*CHAN_W)'(cfg.tint[15:8]) * (2*CHAN_W)'(lv4);
      pb5 <= (2*CHAN_W)'(cfg.tint[7:0]) * (2*CHAN_W)'(lv4);
    end
  end

  // Stage 6: divide by 255 into the output register; pixels off the panel are black.
  logic [32:0] dr;
  logic [32:0] dg;
  logic [32:0] db;

  always_comb begin
    dr = 33'(pr5) * 33'(DIV255_MUL);
    dg = 33'(pg5) * 33'(DIV255_MUL);
    db = 33'(pb5) * 33'(DIV255_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.x     <= px5.x;
      res.y     <= px5.y;
      res.sw    <= px5.sw;
      res.oor   <= px5.oor;
      res.red   <= px5.oor ? '0 : dr[24 +: CHAN_W];
      res.green <= px5.oor ? '0 : dg[24 +: CHAN_W];
      res.blue  <= px5.oor ? '0 : db[24 +: CHAN_W];
    end
  end

endmodule

// File: rtl/core/plasma_pixel_generator.sv
// Top level of the plasma pixel generator: configuration registers and pipeline.
//
// The generator takes one pixel request per clock while in_ready is high and returns
// one colored pixel per request, in request order. A result leaves through 20 register
// stages (5 front-end stages for time and phase, 9 square-root stages, 6 color stages).
// The only state carried from pixel to pixel is the time accumulator, updated within
// front-end stage 3, so a pixel can follow whenever the pipeline advances. When the
// output is not taken the whole pipeline holds and in_ready drops; nothing is lost
// or repeated. Configuration writes take effect at once and are meant to be made
// while no pixels are in flight.
module plasma_pixel_generator
  import ppg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 frame_start,
  input  logic [ELAPSED_W-1:0] elapsed_ms,
  input  logic [X_W-1:0]       pixel_x,
  input  logic [Y_W-1:0]       pixel_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [X_W-1:0]       out_x,
  output logic [Y_W-1:0]       out_y,
  output logic [CHAN_W-1:0]    red,
  output logic [CHAN_W-1:0]    green,
  output logic [CHAN_W-1:0]    blue,
  output logic                 switch_window,
  output logic                 out_of_range
);

  cfg_t    cfg;
  front_t  front;
  root_t   root;
  result_t res;
  logic    en;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed  <= SPEED_RESET;
      cfg.tint   <= TINT_RESET;
      cfg.invert <= 1'b0;
      cfg.width  <= WIDTH_RESET;
      cfg.height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED:  cfg.speed  <= cfg_data[SPEED_W-1:0];
        REG_TINT:   cfg.tint   <= cfg_data[TINT_W-1:0];
        REG_INVERT: cfg.invert <= cfg_data[0];
        REG_WIDTH:  cfg.width  <= cfg_data[PW_W-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[PH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The pipeline advances unless a finished pixel is waiting for its transfer.
  assign en       = !res.valid || out_ready;
  assign in_ready = en;

  ppg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .frame_start (frame_start),
    .elapsed_ms  (elapsed_ms),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .front       (front)
  );

  ppg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .front (front),
    .root  (root)
  );

  ppg_color u_color (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .cfg  (cfg),
    .root (root),
    .res  (res)
  );

  assign out_valid     = res.valid;
  assign out_x         = res.x;
  assign out_y         = res.y;
  assign red           = res.red;
  assign green         = res.green;
  assign blue          = res.blue;
  assign switch_window = res.sw;
  assign out_of_range  = res.oor;

endmodule

// File: tb/sv/plasma_pixel_generator_tb.sv
// Self-checking testbench of the plasma pixel generator with a pixel scoreboard.
`timescale 1ns / 100ps

module plasma_pixel_generator_tb;
  import ppg_pkg::*;

  // One expected output pixel.
  typedef struct {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              sw;
    logic              oor;
  } pixel_t;

  // Plasma predictor plus the queue of pixels still owed by the block.
  class plasma_scoreboard;
    int unsigned speed, tint, invert, width, height, clock_ms;
    int          sine_mag [0:SINE_TABLE_DEPTH];
    pixel_t      owed [$];
    int          errors;

    function new();
      longint unsigned a, a2, term;
      longint          acc;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
        a    = longint'(i) * longint'(HALF_PI_Q30) / SINE_TABLE_DEPTH;
        a2   = (a * a) >> 30;
        term = a;
        acc  = a;
        // Odd Taylor terms with truncated magnitudes.
        for (int k = 1; k <= 5; k++) begin
          term = ((term * a2) >> 30) / ((2 * k) * (2 * k + 1));
          acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        sine_mag[i] = int'((longint'(acc) + 32768) >> 16);
      end
      errors = 0;
      restart();
    endfunction

    function void restart();
      speed = 50; tint = 24'h40C0FF; invert = 0; width = 40; height = 12; clock_ms = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SPEED:  speed  = data & 24'h3FF;
        REG_TINT:   tint   = data;
        REG_INVERT: invert = data & 24'h1;
        REG_WIDTH:  width  = data & 24'h7F;
        REG_HEIGHT: height = data & 24'h1F;
        default: ;
      endcase
    endfunction

    function int wave(int unsigned p);
      int unsigned quad, idx;
      quad = (p >> 14) & 3;
      idx  = ((p & 16'h3FFF) * SINE_TABLE_DEPTH) >> 14;
      if (quad & 1) idx = SINE_TABLE_DEPTH - idx;
      return (quad & 2) ? -sine_mag[idx] : sine_mag[idx];
    endfunction

    function int unsigned root(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 34;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv >>= 2;
      end
      return int'(res);
    endfunction

    function int unsigned turns(int unsigned rate);
      return int'((longint'(clock_ms) * rate) >> 16) & 16'hFFFF;
    endfunction

    // Predict the pixel of one accepted request.
    function void note_request(bit fs, int unsigned el, int unsigned x, int unsigned y);
      pixel_t      px;
      int unsigned w, h, fx, fy, rad, p1, p2, p3, s, v;
      int          total;
      w = (width < MAX_WIDTH) ? width : MAX_WIDTH;
      h = (height < MAX_HEIGHT) ? height : MAX_HEIGHT;
      if (fs) clock_ms = (clock_ms + el * speed / 50) % PERIOD_MS;
      px.x = x; px.y = y; px.red = 0; px.green = 0; px.blue = 0;
      px.oor = (x >= w || y >= h);
      px.sw  = (clock_ms % 1000) < WINDOW_MS;
      if (!px.oor) begin
        fx  = (x << 16) / w;
        fy  = (y << 16) / h;
        rad = root(longint'(fx) * fx + longint'(fy) * fy);
        p1  = (fx + turns(RATE_10)) & 16'hFFFF;
        p2  = (((fx + fy) >> 1) - turns(RATE_07)) & 16'hFFFF;
        p3  = (rad - turns(RATE_13)) & 16'hFFFF;
        total = wave(p1) + wave(p2) + wave(p3) + LEVEL_BIAS;
        if (total < 0) total = 0;
        if (total > LEVEL_FULL) total = LEVEL_FULL;
        s = total;
        if (invert) s = LEVEL_FULL - s;
        v = s * 255 / LEVEL_FULL;
        px.red   = ((tint >> 16) & 8'hFF) * v / 255;
        px.green = ((tint >> 8) & 8'hFF) * v / 255;
        px.blue  = (tint & 8'hFF) * v / 255;
      end
      owed.push_back(px);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // Compare one output transfer with the oldest owed pixel.
    task check_pixel(pixel_t got);
      pixel_t want;
      if (owed.size() == 0) begin
        report_mismatch("unexpected pixel x", got.x, -1);
        return;
      end
      want = owed.pop_front();
      if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
      if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
      if (got.red !== want.red) report_mismatch("red", got.red, want.red);
      if (got.green !== want.green) report_mismatch("green", got.green, want.green);
      if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
      if (got.sw !== want.sw) report_mismatch("switch_window", got.sw, want.sw);
      if (got.oor !== want.oor) report_mismatch("out_of_range", got.oor, want.oor);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 frame_start = 1'b0;
  logic [ELAPSED_W-1:0] elapsed_ms = '0;
  logic [X_W-1:0]       pixel_x = '0;
  logic [Y_W-1:0]       pixel_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [X_W-1:0]       out_x;
  logic [Y_W-1:0]       out_y;
  logic [CHAN_W-1:0]    red, green, blue;
  logic                 switch_window, out_of_range;

  plasma_scoreboard sb = new();
  bit steady = 1'b0;     // no idling on either side
  bit hold_req = 1'b0;   // asks the receiver for a long hold-off
  int hold_left = 0;

  plasma_pixel_generator uut (.*);

  always #4 clk = ~clk;

  // Output side: check each transfer, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel('{out_x, out_y, red, green, blue, switch_window, out_of_range});
    if (hold_req && hold_left == 0) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic setup(int sp, int tn, int inv, int w, int h);
    write_reg(REG_SPEED, CFG_W'(sp));
    write_reg(REG_TINT, CFG_W'(tn));
    write_reg(REG_INVERT, CFG_W'(inv));
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
  endtask

  // Offer one request and return at the edge of its transfer.
  task automatic send_pixel(bit fs, int el, int x, int y);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    frame_start <= fs;
    elapsed_ms  <= ELAPSED_W'(el);
    pixel_x     <= X_W'(x);
    pixel_y     <= Y_W'(y);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(fs, el, x, y);
  endtask

  // Pause the input until every owed pixel has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Random requests, mostly on the active panel with short frame steps.
  task automatic random_pixels(int count);
    int w, h, x, y, el, r;
    w = (sb.width < MAX_WIDTH) ? sb.width : MAX_WIDTH;
    h = (sb.height < MAX_HEIGHT) ? sb.height : MAX_HEIGHT;
    for (int i = 0; i < count; i++) begin
      if (w > 0 && h > 0 && $urandom_range(99) < 85) begin
        x = $urandom_range(w - 1);
        y = $urandom_range(h - 1);
      end else begin
        x = $urandom_range(63);
        y = $urandom_range(15);
      end
      r  = $urandom_range(99);
      el = (r < 70) ? $urandom_range(60) : (r < 92) ? $urandom_range(1023) :
           (r < 96) ? 1000 : 1023;
      send_pixel($urandom_range(7) == 0, el, x, y);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: corners, out-of-range rows and columns, time steps.
    send_pixel(1, 0, 0, 0);
    send_pixel(0, 0, 39, 11);
    send_pixel(0, 0, 40, 0);
    send_pixel(0, 0, 0, 12);
    send_pixel(0, 0, 63, 15);
    send_pixel(1, 1023, 5, 5);
    send_pixel(1, 1000, 20, 6);
    send_pixel(1, 1, 1, 1);
    for (int i = 0; i < 6; i++) send_pixel(1, 960 + i * 7, i * 6, i);
    drain();

    // Largest register values, panel wider than the maximum, unknown indexes.
    setup(1023, 24'hFFFFFF, 1, 127, 31);
    for (int i = int'(REG_HEIGHT) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_W'(24'h123456 + i));
    send_pixel(1, 1023, 63, 15);
    send_pixel(0, 0, 0, 0);
    send_pixel(1, 1023, 32, 8);
    send_pixel(1, 1023, 1, 15);
    drain();

    // Empty panel: every pixel out of range.
    setup(0, 0, 0, 0, 0);
    send_pixel(1, 1023, 0, 0);
    send_pixel(0, 0, 63, 15);
    drain();

    // Smallest panel and nominal speed.
    setup(50, 24'h808080, 0, 1, 1);
    send_pixel(1, 40, 0, 0);
    send_pixel(0, 0, 1, 0);
    drain();

    // Random phases; the first runs without idling, the second with a hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) setup(50, 24'h40C0FF, 0, 64, 16);
      else setup($urandom_range(1023), $urandom_range(24'hFFFFFF), $urandom_range(1),
                 $urandom_range(70, 1), $urandom_range(18, 1));
      steady = (ph == 0);
      if (ph == 1) hold_req = 1'b1;
      random_pixels(125);
      drain();
      random_pixels(125);
      drain();
      steady = 1'b0;
    end

    in_valid <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
